[rtl/kmsd_pkg.sv]
// Shared types, key codes and decode tables of the key matrix scan decoder.
`default_nettype none

package kmsd_pkg;

    localparam int NumRows = 12;
    localparam int RowBits = 8;

    typedef logic [NumRows-1:0][RowBits-1:0] matrix_t;
    typedef logic [3:0]                      row_idx_t;
    typedef logic [2:0]                      bit_idx_t;
    typedef logic [7:0]                      code_t;
    typedef logic [6:0]                      count_t;

    // Modifier key positions
    localparam row_idx_t SHIFT_ROW = 4'd2;
    localparam bit_idx_t SHIFT_BIT = 3'd5;
    localparam row_idx_t CAPS_ROW  = 4'd8;
    localparam bit_idx_t CAPS_BIT  = 3'd6;
    localparam row_idx_t ALT_ROW   = 4'd10;
    localparam bit_idx_t ALT_BIT   = 3'd7;

    // Keys that never count as down: shift, caps lock, alt
    localparam matrix_t MOD_MASK = {8'h00, 8'h80, 8'h00, 8'h40, 8'h00, 8'h00,
                                    8'h00, 8'h00, 8'h00, 8'h20, 8'h00, 8'h00};

    localparam count_t ROLLOVER_RESET = 7'd3;
    localparam count_t PRESSED_MAX    = 7'd93;

    // Alt reduces this code range to its low five bits
    localparam code_t ALT_LOW  = 8'd32;
    localparam code_t ALT_HIGH = 8'd95;
    localparam code_t CASE_GAP = 8'h20;

    // Special key codes
    localparam code_t K_NONE   = 8'h00;
    localparam code_t K_TAB    = 8'h09;
    localparam code_t K_CR     = 8'h0D;
    localparam code_t K_ESC    = 8'h1B;
    localparam code_t K_DQUOTE = 8'h22;
    localparam code_t K_QUOTE  = 8'h27;
    localparam code_t K_DEL    = 8'h7F;
    localparam code_t K_F1     = 8'h80;
    localparam code_t K_F2     = 8'h81;
    localparam code_t K_F3     = 8'h82;
    localparam code_t K_F4     = 8'h83;
    localparam code_t K_F5     = 8'h84;
    localparam code_t K_F7     = 8'h86;
    localparam code_t K_PASTE  = 8'h90;
    localparam code_t K_COPY   = 8'h91;
    localparam code_t K_CUT    = 8'h92;
    localparam code_t K_PRINT  = 8'h93;
    localparam code_t K_EXIT   = 8'h94;
    localparam code_t K_PLUS   = 8'h95;
    localparam code_t K_MINUS  = 8'h96;
    localparam code_t K_DELR   = 8'h97;
    localparam code_t K_CANCEL = 8'h98;
    localparam code_t K_DOT    = 8'h99;
    localparam code_t K_STOP   = 8'h9A;
    localparam code_t K_POUND  = 8'hA3;
    localparam code_t K_HALF   = 8'hBD;

    // Indexed [row][7 - bit]
    localparam code_t PLAIN_TABLE [NumRows][RowBits] = '{
        '{"2", "3", "6", "9", K_PASTE, K_F1, "0", K_F3},
        '{"1", "5", "4", "8", K_COPY, K_CUT, K_PRINT, K_EXIT},
        '{K_PLUS, K_HALF, K_NONE, "7", "#", K_CR, "]", K_DELR},
        '{".", "/", ";", "$", "p", "[", "-", "="},
        '{",", "m", "k", "l", "i", "o", "9", "0"},
        '{" ", "n", "j", "h", "y", "u", "7", "8"},
        '{"v", "b", "f", "g", "t", "r", "5", "6"},
        '{"x", "c", "d", "s", "w", "e", "3", "4"},
        '{"z", K_NONE, "a", K_TAB, "q", K_ESC, "2", "1"},
        '{K_DEL, ".", K_CR, K_F7, K_MINUS, K_CANCEL, K_NONE, K_F5},
        '{K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE},
        '{K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE}
    };

    localparam code_t SHIFT_TABLE [NumRows][RowBits] = '{
        '{"2", "3", "6", "9", K_PASTE, K_F2, "0", K_F4},
        '{"1", "5", "4", "8", K_COPY, K_CUT, K_PRINT, K_EXIT},
        '{K_PLUS, "@", K_NONE, "7", ">", K_CR, "}", K_DELR},
        '{K_DOT, "?", ":", "<", "P", "{", "_", "+"},
        '{K_QUOTE, "M", "K", "L", "I", "O", "(", ")"},
        '{" ", "N", "J", "H", "Y", "U", "&", "*"},
        '{"V", "B", "F", "G", "T", "R", "%", "^"},
        '{"X", "C", "D", "S", "W", "E", K_POUND, "$"},
        '{"Z", K_NONE, "A", K_TAB, "Q", K_STOP, K_DQUOTE, "!"},
        '{K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE},
        '{K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE},
        '{K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE, K_NONE}
    };

    typedef struct packed {
        count_t keys_down;
        logic   caps_lock;
        count_t rollover_limit;
    } scan_state_t;

    typedef struct packed {
        logic   code_valid;
        code_t  key_code;
        count_t pressed_count;
        logic   caps_toggle;
    } scan_result_t;

endpackage

`default_nettype wire

[rtl/key_matrix_scan_decoder.sv]
// Top level of the key matrix scan decoder: input register, decode, result register.
//
// Usage:
//   Input channel (s_valid/s_ready): one item is a 12 x 8 matrix snapshot on
//   s_row_0 .. s_row_11, a set bit meaning the key is down.
//   Result channel (m_valid/m_ready): every item yields exactly one result:
//   m_code_valid, m_key_code and m_pressed_count.
//   Configuration: cfg_we writes cfg_wdata into the rollover limit (reset 3);
//   write it only while no item is in flight.
// Timing:
//   An item is held in the input register, then the compare, count and
//   table lookup run in one combinational pass into the result register,
//   which drives m_valid. One item per cycle is sustained while m_ready
//   stays high: the stored snapshot and key count are updated as each item
//   leaves the input register, so the next item sees them while it is held
//   there.
// Reset (aresetn low, synchronous): clears the stored snapshot, key count,
//   caps lock, both valid flags, and sets the rollover limit to 3.
// Stall: while m_ready is low the result holds; the input register keeps
//   accepting until it too is full, then s_ready drops.
`default_nettype none

module key_matrix_scan_decoder (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // configuration
    input  wire logic       cfg_we,
    input  wire logic [6:0] cfg_wdata,
    // input items
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_row_0,
    input  wire logic [7:0] s_row_1,
    input  wire logic [7:0] s_row_2,
    input  wire logic [7:0] s_row_3,
    input  wire logic [7:0] s_row_4,
    input  wire logic [7:0] s_row_5,
    input  wire logic [7:0] s_row_6,
    input  wire logic [7:0] s_row_7,
    input  wire logic [7:0] s_row_8,
    input  wire logic [7:0] s_row_9,
    input  wire logic [7:0] s_row_10,
    input  wire logic [7:0] s_row_11,
    // result items
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_code_valid,
    output logic [7:0]      m_key_code,
    output logic [6:0]      m_pressed_count
);

    kmsd_pkg::matrix_t     s_rows;
    kmsd_pkg::matrix_t     in_rows_reg;
    logic                  in_valid_reg;
    kmsd_pkg::matrix_t     prev_rows_reg;
    kmsd_pkg::count_t      keys_down_reg;
    logic                  caps_lock_reg;
    kmsd_pkg::count_t      limit_reg;
    logic                  out_valid_reg;
    logic                  out_code_valid_reg;
    kmsd_pkg::code_t       out_key_code_reg;
    kmsd_pkg::count_t      out_count_reg;

    kmsd_pkg::scan_state_t  scan_state;
    kmsd_pkg::scan_result_t scan_result;

    logic out_free;
    logic advance;
    logic accept;

    assign s_rows = {s_row_11, s_row_10, s_row_9, s_row_8, s_row_7, s_row_6,
                     s_row_5, s_row_4, s_row_3, s_row_2, s_row_1, s_row_0};

    // Result slot is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || m_ready;
    // Move the held item into the result register
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign accept   = s_valid && s_ready;

    assign scan_state.keys_down      = keys_down_reg;
    assign scan_state.caps_lock      = caps_lock_reg;
    assign scan_state.rollover_limit = limit_reg;

    kmsd_decode u_decode (
        .cur_rows  (in_rows_reg),
        .prev_rows (prev_rows_reg),
        .state     (scan_state),
        .result    (scan_result)
    );

    // Input stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input payload: capture on accept, hold otherwise
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_rows_reg <= s_rows;
        end
    end

    // Scan state advances once per item, as the item enters the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_rows_reg <= '0;
            keys_down_reg <= '0;
            caps_lock_reg <= 1'b0;
        end else if (advance) begin
            prev_rows_reg <= in_rows_reg;
            keys_down_reg <= scan_result.pressed_count;
            caps_lock_reg <= caps_lock_reg ^ scan_result.caps_toggle;
        end
    end

    // Rollover limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= kmsd_pkg::ROLLOVER_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    // Result stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload: load on advance, hold while stalled
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_code_valid_reg <= scan_result.code_valid;
            out_key_code_reg   <= scan_result.key_code;
            out_count_reg      <= scan_result.pressed_count;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_code_valid    = out_code_valid_reg;
    assign m_key_code      = out_key_code_reg;
    assign m_pressed_count = out_count_reg;

endmodule

`default_nettype wire

[rtl/kmsd_decode.sv]
// Snapshot compare, key count update and key code lookup for one matrix scan.
`default_nettype none

module kmsd_decode (
    input  kmsd_pkg::matrix_t      cur_rows,
    input  kmsd_pkg::matrix_t      prev_rows,
    input  kmsd_pkg::scan_state_t  state,
    output kmsd_pkg::scan_result_t result
);

    kmsd_pkg::matrix_t    rose;
    kmsd_pkg::matrix_t    fell;
    kmsd_pkg::count_t     up_count;
    kmsd_pkg::count_t     down_count;
    kmsd_pkg::count_t     keys_next;
    kmsd_pkg::bit_idx_t   row_lsb [kmsd_pkg::NumRows];
    logic                 found;
    kmsd_pkg::row_idx_t   hit_row;
    kmsd_pkg::bit_idx_t   hit_bit;
    kmsd_pkg::bit_idx_t   col;
    kmsd_pkg::code_t      raw_code;
    kmsd_pkg::code_t      alt_code;
    kmsd_pkg::code_t      final_code;
    logic                 decode_ok;
    logic                 caps_key;

    assign rose       = cur_rows & ~prev_rows;
    assign fell       = prev_rows & ~cur_rows;
    assign up_count   = 7'($countones(rose & ~kmsd_pkg::MOD_MASK));
    assign down_count = 7'($countones(fell & ~kmsd_pkg::MOD_MASK));
    assign keys_next  = state.keys_down + up_count - down_count;

    // Lowest newly set bit of each row
    always_comb begin
        for (int r = 0; r < kmsd_pkg::NumRows; r++) begin
            row_lsb[r] = '0;
            for (int b = kmsd_pkg::RowBits - 1; b >= 0; b--) begin
                if (rose[r][b]) begin
                    row_lsb[r] = 3'(b);
                end
            end
        end
    end

    // Highest row with a new press wins
    always_comb begin
        found   = 1'b0;
        hit_row = '0;
        hit_bit = '0;
        for (int r = 0; r < kmsd_pkg::NumRows; r++) begin
            if (|rose[r]) begin
                found   = 1'b1;
                hit_row = 4'(r);
                hit_bit = row_lsb[r];
            end
        end
    end

    assign col      = ~hit_bit;
    assign raw_code = cur_rows[kmsd_pkg::SHIFT_ROW][kmsd_pkg::SHIFT_BIT]
                    ? kmsd_pkg::SHIFT_TABLE[hit_row][col]
                    : kmsd_pkg::PLAIN_TABLE[hit_row][col];

    always_comb begin
        alt_code = raw_code;
        if (cur_rows[kmsd_pkg::ALT_ROW][kmsd_pkg::ALT_BIT]
            && raw_code inside {[kmsd_pkg::ALT_LOW:kmsd_pkg::ALT_HIGH]}) begin
            alt_code = {3'b000, raw_code[4:0]};
        end
        final_code = alt_code;
        if (state.caps_lock && alt_code inside {["a":"z"]}) begin
            final_code = alt_code - kmsd_pkg::CASE_GAP;
        end
    end

    assign decode_ok = found && (keys_next < state.rollover_limit);
    assign caps_key  = (hit_row == kmsd_pkg::CAPS_ROW) && (hit_bit == kmsd_pkg::CAPS_BIT);

    always_comb begin
        result.code_valid    = decode_ok && !caps_key;
        result.key_code      = (decode_ok && !caps_key) ? final_code : kmsd_pkg::K_NONE;
        result.pressed_count = keys_next;
        result.caps_toggle   = decode_ok && caps_key;
    end

endmodule

`default_nettype wire

[rtl/kmsd_checker.sv]
// Port-level checks of the key matrix scan decoder and their binding.
`default_nettype none

module kmsd_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_code_valid,
    input wire logic [7:0] m_key_code,
    input wire logic [6:0] m_pressed_count
);

    // Result channel comes up empty after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_key_code)
            && $stable(m_code_valid) && $stable(m_pressed_count))
        else $error("stalled result changed");

    // With the result slot empty the input is always open
    a_ready_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with an empty result slot");

    // No code means a zero key code
    a_no_code_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_code_valid |-> m_key_code == kmsd_pkg::K_NONE)
        else $error("key code set without code valid");

    // The count follows the stored snapshot, so it stays within the matrix
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_pressed_count <= kmsd_pkg::PRESSED_MAX)
        else $error("pressed count out of range");

endmodule

bind key_matrix_scan_decoder kmsd_checker u_kmsd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_code_valid    (m_code_valid),
    .m_key_code      (m_key_code),
    .m_pressed_count (m_pressed_count)
);

`default_nettype wire
